// ===== rtl/gccc_pkg.sv =====
// ----------------------------------------------------------------------------
// gccc_pkg
// shared types and constants for the graph cycle and component checker
// ----------------------------------------------------------------------------
package gccc_pkg;

    localparam int DEF_MAX_VERTICES = 128;
    localparam int DEF_MAX_DEGREE   = 128;

    localparam int VERTEX_W  = 7;
    localparam int COUNT_W   = 8;

    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 8'd128;
    localparam logic [COUNT_W-1:0] COMP_MAX     = 8'd255;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_ANALYZE  = 1'b1;

    // analyze result word
    typedef struct packed {
        logic               has_cycle;
        logic [COUNT_W-1:0] component_count;
        logic               load_error;
    } t_result;

    // write enables of the three stores
    typedef struct packed {
        logic adj;
        logic vinfo;
        logic stack;
    } t_mem_we;

endpackage

// ===== rtl/gccc_ram.sv =====
// ----------------------------------------------------------------------------
// gccc_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gccc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gccc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gccc_ctrl
// sequencer for edge loading, depth-first walk and clearing sweep
// ----------------------------------------------------------------------------
module gccc_ctrl #(
    parameter int MAX_VERTICES = gccc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = gccc_pkg::DEF_MAX_DEGREE,
    parameter int VW  = $clog2(MAX_VERTICES),
    parameter int CW  = $clog2(MAX_VERTICES + 1),
    parameter int DW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1,
    parameter int DGW = $clog2(MAX_DEGREE + 1),
    parameter int VIW = 2 + VW + DGW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_command,
    input  logic [gccc_pkg::VERTEX_W-1:0] i_vertex_a,
    input  logic [gccc_pkg::VERTEX_W-1:0] i_vertex_b,
    input  logic [CW-1:0]                 i_n,
    output logic                          o_busy,
    output gccc_pkg::t_result             o_res,
    output logic                          o_res_valid,
    output gccc_pkg::t_mem_we             o_we,
    output logic [VW+DW-1:0]              o_adj_waddr,
    output logic [VW-1:0]                 o_adj_wdata,
    output logic [VW+DW-1:0]              o_adj_raddr,
    input  logic [VW-1:0]                 i_adj_rdata,
    output logic [VW-1:0]                 o_vi_waddr,
    output logic [VIW-1:0]                o_vi_wdata,
    output logic [VW-1:0]                 o_vi_raddr,
    input  logic [VIW-1:0]                i_vi_rdata,
    output logic [VW-1:0]                 o_st_waddr,
    output logic [VW-1:0]                 o_st_wdata,
    output logic [VW-1:0]                 o_st_raddr,
    input  logic [VW-1:0]                 i_st_rdata
);

    localparam int EW = (CW > gccc_pkg::VERTEX_W) ? CW : gccc_pkg::VERTEX_W;
    localparam int SW = (CW > gccc_pkg::COUNT_W) ? CW : gccc_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_E_RDA, S_E_RDB, S_E_WRB,
        S_OUTER, S_ROOT, S_POP, S_POPW, S_ULOAD, S_NBR, S_NBRW, S_CHK
    } t_state;

    t_state            r_state, n_state;
    logic [VW-1:0]     r_a, n_a, r_b, n_b;
    logic [VIW-1:0]    r_rec_a, n_rec_a, r_rec_b, n_rec_b;
    logic              r_err, n_err;
    logic              r_cyc, n_cyc;
    logic [CW-1:0]     r_v, n_v;
    logic [CW-1:0]     r_comps, n_comps;
    logic [CW-1:0]     r_depth, n_depth;
    logic [VW-1:0]     r_u, n_u;
    logic [DGW-1:0]    r_u_deg, n_u_deg;
    logic              r_u_pv, n_u_pv;
    logic [VW-1:0]     r_u_par, n_u_par;
    logic [DGW-1:0]    r_i, n_i;
    logic [VW-1:0]     r_w, n_w;
    logic [VW-1:0]     r_clr, n_clr;
    gccc_pkg::t_result r_res, n_res;
    logic              r_res_valid, n_res_valid;

    // record fields of the vertex info word
    logic [DGW-1:0]    rd_deg;
    logic [VW-1:0]     rd_par;
    logic              rd_pv, rd_vis;
    logic [DGW-1:0]    deg_a;
    logic [DGW:0]      deg_a_p2;
    logic              self_loop;
    logic              a_bad, b_bad;
    logic [SW-1:0]     comps_ext;

    assign rd_deg    = i_vi_rdata[DGW-1:0];
    assign rd_par    = i_vi_rdata[DGW +: VW];
    assign rd_pv     = i_vi_rdata[DGW + VW];
    assign rd_vis    = i_vi_rdata[DGW + VW + 1];
    assign deg_a     = r_rec_a[DGW-1:0];
    assign deg_a_p2  = {1'b0, deg_a} + (DGW + 1)'(2);
    assign self_loop = (r_a == r_b);
    assign a_bad     = EW'(i_vertex_a) >= EW'(i_n);
    assign b_bad     = EW'(i_vertex_b) >= EW'(i_n);
    assign comps_ext = SW'(r_comps);

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_rec_a     = r_rec_a;
        n_rec_b     = r_rec_b;
        n_err       = r_err;
        n_cyc       = r_cyc;
        n_v         = r_v;
        n_comps     = r_comps;
        n_depth     = r_depth;
        n_u         = r_u;
        n_u_deg     = r_u_deg;
        n_u_pv      = r_u_pv;
        n_u_par     = r_u_par;
        n_i         = r_i;
        n_w         = r_w;
        n_clr       = r_clr;
        n_res       = r_res;
        n_res_valid = 1'b0;
        o_we        = '0;
        o_adj_waddr = {r_a, deg_a[DW-1:0]};
        o_adj_wdata = r_b;
        o_adj_raddr = {r_u, r_i[DW-1:0]};
        o_vi_waddr  = r_a;
        o_vi_wdata  = '0;
        o_vi_raddr  = VW'(i_vertex_a);
        o_st_waddr  = r_depth[VW-1:0];
        o_st_wdata  = r_w;
        o_st_raddr  = VW'(r_depth - CW'(1));

        case (r_state)
            S_CLEAR: begin
                o_we.vinfo = 1'b1;
                o_vi_waddr = r_clr;
                o_vi_wdata = '0;
                n_err      = 1'b0;
                n_cyc      = 1'b0;
                n_comps    = '0;
                n_v        = '0;
                n_depth    = '0;
                if (r_clr == VW'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + VW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_command == gccc_pkg::CMD_ANALYZE) begin
                        n_state = S_OUTER;
                    end else if (a_bad || b_bad) begin
                        n_err = 1'b1;
                    end else begin
                        n_a     = VW'(i_vertex_a);
                        n_b     = VW'(i_vertex_b);
                        n_state = S_E_RDA;
                    end
                end
            end
            S_E_RDA: begin
                n_rec_a    = i_vi_rdata;
                o_vi_raddr = r_b;
                n_state    = S_E_RDB;
            end
            S_E_RDB: begin
                n_rec_b = i_vi_rdata;
                n_state = S_IDLE;
                if (self_loop ? (deg_a_p2 > (DGW + 1)'(MAX_DEGREE))
                              : (deg_a >= DGW'(MAX_DEGREE) ||
                                 rd_deg >= DGW'(MAX_DEGREE))) begin
                    n_err = 1'b1;
                end else begin
                    o_we.adj   = 1'b1;
                    o_we.vinfo = 1'b1;
                    o_vi_waddr = r_a;
                    o_vi_wdata = {r_rec_a[VIW-1:DGW],
                                  self_loop ? deg_a_p2[DGW-1:0] : deg_a + DGW'(1)};
                    n_state    = S_E_WRB;
                end
            end
            S_E_WRB: begin
                o_we.adj = 1'b1;
                n_state  = S_IDLE;
                if (self_loop) begin
                    o_adj_waddr = {r_a, DW'(deg_a + DGW'(1))};
                    o_adj_wdata = r_a;
                end else begin
                    o_adj_waddr = {r_b, r_rec_b[DW-1:0]};
                    o_adj_wdata = r_a;
                    o_we.vinfo  = 1'b1;
                    o_vi_waddr  = r_b;
                    o_vi_wdata  = {r_rec_b[VIW-1:DGW], r_rec_b[DGW-1:0] + DGW'(1)};
                end
            end
            S_OUTER: begin
                o_vi_raddr = r_v[VW-1:0];
                if (r_v == i_n) begin
                    n_res.has_cycle       = r_cyc;
                    n_res.component_count = (comps_ext > SW'(gccc_pkg::COMP_MAX))
                                          ? gccc_pkg::COMP_MAX
                                          : gccc_pkg::COUNT_W'(comps_ext);
                    n_res.load_error      = r_err;
                    n_res_valid           = 1'b1;
                    n_clr                 = '0;
                    n_state               = S_CLEAR;
                end else begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (rd_vis) begin
                    n_v     = r_v + CW'(1);
                    n_state = S_OUTER;
                end else begin
                    // new root: mark visited with no parent and push it
                    o_we.vinfo = 1'b1;
                    o_vi_waddr = r_v[VW-1:0];
                    o_vi_wdata = {1'b1, 1'b0, rd_par, rd_deg};
                    o_we.stack = 1'b1;
                    o_st_waddr = '0;
                    o_st_wdata = r_v[VW-1:0];
                    n_depth    = CW'(1);
                    n_comps    = r_comps + CW'(1);
                    n_state    = S_POP;
                end
            end
            S_POP: begin
                if (r_depth == '0) begin
                    n_v     = r_v + CW'(1);
                    n_state = S_OUTER;
                end else begin
                    n_depth = r_depth - CW'(1);
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_u        = i_st_rdata;
                o_vi_raddr = i_st_rdata;
                n_state    = S_ULOAD;
            end
            S_ULOAD: begin
                n_u_deg = rd_deg;
                n_u_pv  = rd_pv;
                n_u_par = rd_par;
                n_i     = '0;
                n_state = S_NBR;
            end
            S_NBR: begin
                if (r_i == r_u_deg) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_NBRW;
                end
            end
            S_NBRW: begin
                o_vi_raddr = i_adj_rdata;
                if (CW'(i_adj_rdata) >= i_n) begin
                    n_i     = r_i + DGW'(1);
                    n_state = S_NBR;
                end else begin
                    n_w     = i_adj_rdata;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_i     = r_i + DGW'(1);
                n_state = S_NBR;
                if (!rd_vis) begin
                    o_we.vinfo = 1'b1;
                    o_vi_waddr = r_w;
                    o_vi_wdata = {1'b1, 1'b1, r_u, rd_deg};
                    if (r_depth < CW'(MAX_VERTICES)) begin
                        o_we.stack = 1'b1;
                        n_depth    = r_depth + CW'(1);
                    end
                end else if (!r_u_pv || r_u_par != r_w) begin
                    n_cyc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_err       <= 1'b0;
            r_cyc       <= 1'b0;
            r_v         <= '0;
            r_comps     <= '0;
            r_depth     <= '0;
            r_i         <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_err       <= n_err;
            r_cyc       <= n_cyc;
            r_v         <= n_v;
            r_comps     <= n_comps;
            r_depth     <= n_depth;
            r_i         <= n_i;
            r_res_valid <= n_res_valid;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_rec_a <= n_rec_a;
        r_rec_b <= n_rec_b;
        r_u     <= n_u;
        r_u_deg <= n_u_deg;
        r_u_pv  <= n_u_pv;
        r_u_par <= n_u_par;
        r_w     <= n_w;
        r_res   <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

// ===== rtl/graph_cycle_and_component_check.sv =====
// ----------------------------------------------------------------------------
// graph_cycle_and_component_check
// undirected graph loader with depth-first cycle and component analysis
// ----------------------------------------------------------------------------
// A word is taken at a clock edge with start high and busy low. An add-edge
// word stores the edge in both endpoint lists, reading both endpoint records
// and then writing each endpoint's list entry and degree in turn. An edge is
// dropped after those reads when a list is full, and without leaving idle
// when an endpoint is at or above the vertex count. A dropped edge sets the
// load error flag. An analyze word walks the graph with a single sequencer
// driving the vertex info, adjacency and stack memories, one access each per
// cycle; the walk is followed by a clearing sweep over all MAX_VERTICES
// vertex info entries. The result word appears for exactly one cycle with
// o_result_valid when the walk ends, at the start of that sweep; the
// receiver cannot stall it, so it must be captured then. After reset the
// same clearing sweep runs with busy high before the first word is taken;
// vertex count writes are taken at any time.
// ----------------------------------------------------------------------------
module graph_cycle_and_component_check #(
    parameter int MAX_VERTICES = gccc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = gccc_pkg::DEF_MAX_DEGREE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // vertex count register
    input  logic                          i_cfg_we,
    input  logic [gccc_pkg::COUNT_W-1:0]  i_cfg_wdata,
    // command word
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [gccc_pkg::VERTEX_W-1:0] i_vertex_a,
    input  logic [gccc_pkg::VERTEX_W-1:0] i_vertex_b,
    // result word
    output logic                          o_result_valid,
    output logic                          o_has_cycle,
    output logic [gccc_pkg::COUNT_W-1:0]  o_component_count,
    output logic                          o_load_error
);

    // vertex index, vertex count, list slot and degree widths
    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int DW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DGW    = $clog2(MAX_DEGREE + 1);
    // vertex info word: visited, parent valid, parent, degree
    localparam int VIW    = 2 + VW + DGW;
    // adjacency is addressed as {vertex, slot}
    localparam int ADEPTH = MAX_VERTICES * (2 ** DW);
    localparam int NW     = (CW > gccc_pkg::COUNT_W) ? CW : gccc_pkg::COUNT_W;

    logic [gccc_pkg::COUNT_W-1:0] r_vertex_count;
    logic [CW-1:0]                eff_n;

    gccc_pkg::t_result            res;
    gccc_pkg::t_mem_we            we;
    logic [VW+DW-1:0]             adj_waddr, adj_raddr;
    logic [VW-1:0]                adj_wdata, adj_rdata;
    logic [VW-1:0]                vi_waddr, vi_raddr;
    logic [VIW-1:0]               vi_wdata, vi_rdata;
    logic [VW-1:0]                st_waddr, st_raddr, st_wdata, st_rdata;

    // vertex count register, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= gccc_pkg::VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    // effective count saturates at the vertex capacity
    assign eff_n = (NW'(r_vertex_count) > NW'(MAX_VERTICES))
                 ? CW'(MAX_VERTICES) : CW'(r_vertex_count);

    gccc_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .VW           (VW),
        .CW           (CW),
        .DW           (DW),
        .DGW          (DGW),
        .VIW          (VIW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_command   (i_command),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .i_n         (eff_n),
        .o_busy      (busy),
        .o_res       (res),
        .o_res_valid (o_result_valid),
        .o_we        (we),
        .o_adj_waddr (adj_waddr),
        .o_adj_wdata (adj_wdata),
        .o_adj_raddr (adj_raddr),
        .i_adj_rdata (adj_rdata),
        .o_vi_waddr  (vi_waddr),
        .o_vi_wdata  (vi_wdata),
        .o_vi_raddr  (vi_raddr),
        .i_vi_rdata  (vi_rdata),
        .o_st_waddr  (st_waddr),
        .o_st_wdata  (st_wdata),
        .o_st_raddr  (st_raddr),
        .i_st_rdata  (st_rdata)
    );

    // neighbor lists, only slots below a vertex's degree are ever used
    gccc_ram #(
        .WIDTH (VW),
        .DEPTH (ADEPTH),
        .AW    (VW + DW)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (we.adj),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // per-vertex degree, visited mark and parent, swept to zero after use
    gccc_ram #(
        .WIDTH (VIW),
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_vinfo_ram (
        .i_clk   (i_clk),
        .i_we    (we.vinfo),
        .i_waddr (vi_waddr),
        .i_wdata (vi_wdata),
        .i_raddr (vi_raddr),
        .o_rdata (vi_rdata)
    );

    // explicit walk stack
    gccc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (we.stack),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign o_has_cycle       = res.has_cycle;
    assign o_component_count = res.component_count;
    assign o_load_error      = res.load_error;

endmodule
